@@ hdl/tmp_pkg.sv @@
// ----------------------------------------------------------------------------
// Trapezoid motion profile package
// Shared widths, register indexes, datapath operation codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmp_pkg;

  // value widths (velocity, position, times, rates)
  localparam int VAL_W  = 31;
  localparam int TS_W   = 16;
  localparam int PROD_W = 64;
  localparam int DVS_W  = 32;
  localparam int SQ_W   = 2 * VAL_W;

  localparam logic [VAL_W-1:0] MAX31 = {VAL_W{1'b1}};

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_VELOCITY = 2'd0,
    REG_ACCEL_RATE   = 2'd1,
    REG_DECEL_RATE   = 2'd2,
    REG_STEP_PERIOD  = 2'd3
  } cfg_reg_t;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MUL_VV,
    OP_MUL_TA,
    OP_CLIP,
    OP_SQ_SET,
    OP_DTA_GO,
    OP_TA_SET,
    OP_DTD_GO,
    OP_TD_SET,
    OP_MUL_PP,
    OP_DQA_GO,
    OP_QA_SET,
    OP_DQD_GO,
    OP_QD_SET,
    OP_DTC_GO,
    OP_TC_SET,
    OP_FIN1,
    OP_FIN2,
    OP_SMP_RATE,
    OP_SMP_VEL,
    OP_SMP_MULP,
    OP_SMP_POS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic func;       // current input item is a tick
    logic tgt_zero;   // current input target is zero
    logic active;     // a profile is running
    logic clip;       // velocity limit squared > target * acceleration
    logic sqrt_done;
    logic div_done;
    logic out_free;   // output register can take a sample
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/tmp_div.sv @@
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// One quotient bit per cycle; the dividend comes left-aligned with the
// number of meaningful bits in steps. Quotient ends up in the low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_div #(
  parameter int DW = 78
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [DW-1:0]             dividend,
  input  wire logic [tmp_pkg::DVS_W-1:0] divisor,
  input  wire logic [$clog2(DW+1)-1:0]   steps,
  output logic      [DW-1:0]             quotient,
  output logic                           done
);
  import tmp_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    z;
  logic [DVS_W-1:0] r;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {r, z[DW-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  // control: load, count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      z   <= dividend;
      r   <= '0;
      dvs <= divisor;
    end else if (busy) begin
      z <= {z[DW-2:0], ge};
      r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient = z;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_div_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");

endmodule

`default_nettype wire

@@ hdl/tmp_sqrt.sv @@
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root, one result bit (two operand bits) per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [tmp_pkg::SQ_W-1:0] operand,
  output logic      [tmp_pkg::VAL_W-1:0] root,
  output logic                          done
);
  import tmp_pkg::*;

  localparam int RW = VAL_W + 2;

  logic [SQ_W-1:0]  x;
  logic [RW-1:0]    r;
  logic [VAL_W-1:0] q;
  logic [4:0]       cnt;
  logic             busy;
  logic [RW+1:0]    rr;
  logic [RW+1:0]    trial;
  logic             ge;

  // bring down two bits and test the next root bit
  always_comb begin
    rr    = {r, x[SQ_W-1:SQ_W-2]};
    trial = {1'b0, q, 2'b01};
    ge    = rr >= trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(VAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // root, remainder and operand shift
  always_ff @(posedge clk) begin
    if (start) begin
      x <= operand;
      r <= '0;
      q <= '0;
    end else if (busy) begin
      x <= {x[SQ_W-3:0], 2'b00};
      r <= ge ? RW'(rr - trial) : rr[RW-1:0];
      q <= {q[VAL_W-2:0], ge};
    end
  end

  assign root = q;

  a_sqrt_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root started while busy");

endmodule

`default_nettype wire

@@ hdl/tmp_dpath.sv @@
// ----------------------------------------------------------------------------
// Trapezoid motion profile datapath
// Configuration registers, profile state, shared multiplier, divider and
// square root, and the output register. Runs one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tmp_pkg::dp_cmd_t          cmd,
  output tmp_pkg::dp_stat_t              stat,
  input  wire logic                      cfg_we,
  input  wire tmp_pkg::cfg_reg_t         cfg_index,
  input  wire logic [tmp_pkg::VAL_W-1:0] cfg_data,
  input  wire logic                      in_func,
  input  wire logic [tmp_pkg::VAL_W-1:0] in_target,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [tmp_pkg::VAL_W-1:0] out_velocity,
  output logic      [tmp_pkg::VAL_W-1:0] out_position,
  output logic                           out_last
);
  import tmp_pkg::*;

  localparam int DW = SQ_W + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [VAL_W-1:0] TC_Q_MAX = MAX31 >> FRAC_BITS;

  typedef enum logic [1:0] {MODE_HOLD, MODE_ACCEL, MODE_DECEL} smp_mode_t;

  // configuration
  logic [VAL_W-1:0] max_velocity, accel_lim, decel_lim;
  logic [TS_W-1:0]  step_period;
  logic [VAL_W-1:0] v_nz, a_nz, d_nz;

  // profile state
  logic [VAL_W-1:0]   target, peak, ta, td, ds, total;
  logic [VAL_W-1:0]   cur_vel, cur_pos;
  logic [31:0]        elapsed;
  logic               active;
  logic [SQ_W-1:0]    vv;
  logic [PROD_W-1:0]  prod;
  logic signed [63:0] dc;
  logic signed [32:0] tc;
  logic signed [33:0] s1;
  smp_mode_t          mode, mode_now;

  // arithmetic units
  logic [DVS_W-1:0]   mul_a, mul_b;
  logic               mul_en;
  logic               div_start, div_done;
  logic [DW-1:0]      div_dividend, div_quo;
  logic [DVS_W-1:0]   div_divisor;
  logic [CW-1:0]      div_steps;
  logic               sq_start, sq_done;
  logic [VAL_W-1:0]   sq_root;

  // derived values
  logic               clip;
  logic [VAL_W-1:0]   quo_cap, tc_mag;
  logic [DW-FRAC_BITS-1:0] quo_hi;
  logic [63:0]        dc_abs;
  logic signed [33:0] s2;
  logic [PROD_W-1:0]  vel_sum, pos_sum, dv;
  logic [VAL_W-1:0]   pos_new;
  logic               last_now;
  logic               out_free;

  // velocity and rate registers written as zero act as one
  assign v_nz = (max_velocity == '0) ? VAL_W'(1) : max_velocity;
  assign a_nz = (accel_lim == '0) ? VAL_W'(1) : accel_lim;
  assign d_nz = (decel_lim == '0) ? VAL_W'(1) : decel_lim;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= VAL_W'(65536);
      accel_lim    <= VAL_W'(65536);
      decel_lim    <= VAL_W'(65536);
      step_period  <= TS_W'(983);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_VELOCITY: max_velocity <= cfg_data;
        REG_ACCEL_RATE:   accel_lim    <= cfg_data;
        REG_DECEL_RATE:   decel_lim    <= cfg_data;
        REG_STEP_PERIOD:  step_period  <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // phase of the sample: ramp up, cruise or ramp down
  always_comb begin
    if (elapsed < {1'b0, ta}) begin
      mode_now = MODE_ACCEL;
    end else if (elapsed >= {1'b0, ds}) begin
      mode_now = MODE_DECEL;
    end else begin
      mode_now = MODE_HOLD;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_VV:   begin mul_a = {1'b0, v_nz};   mul_b = {1'b0, v_nz}; end
      OP_MUL_TA:   begin mul_a = {1'b0, target}; mul_b = {1'b0, a_nz}; end
      OP_MUL_PP:   begin mul_a = {1'b0, peak};   mul_b = {1'b0, peak}; end
      OP_SMP_RATE: begin
        mul_a = {1'b0, (mode_now == MODE_DECEL) ? d_nz : a_nz};
        mul_b = DVS_W'(step_period);
      end
      OP_SMP_MULP: begin mul_a = {1'b0, cur_vel}; mul_b = DVS_W'(step_period); end
      default:     mul_en = 1'b0;
    endcase
  end

  // divider operand select, dividend left-aligned
  always_comb begin
    div_start    = 1'b1;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    case (cmd.op)
      OP_DTA_GO: begin
        div_dividend = {peak, {(DW-VAL_W){1'b0}}};
        div_divisor  = {1'b0, a_nz};
        div_steps    = CW'(VAL_W + FRAC_BITS);
      end
      OP_DTD_GO: begin
        div_dividend = {peak, {(DW-VAL_W){1'b0}}};
        div_divisor  = {1'b0, d_nz};
        div_steps    = CW'(VAL_W + FRAC_BITS);
      end
      OP_DQA_GO: begin
        div_dividend = {prod[SQ_W-1:0], {FRAC_BITS{1'b0}}};
        div_divisor  = {a_nz, 1'b0};
        div_steps    = CW'(SQ_W);
      end
      OP_DQD_GO: begin
        div_dividend = {prod[SQ_W-1:0], {FRAC_BITS{1'b0}}};
        div_divisor  = {d_nz, 1'b0};
        div_steps    = CW'(SQ_W);
      end
      OP_DTC_GO: begin
        div_dividend = {dc_abs[SQ_W-1:0], {FRAC_BITS{1'b0}}};
        div_divisor  = {1'b0, peak};
        div_steps    = CW'(DW);
      end
      default: div_start = 1'b0;
    endcase
  end

  // derived terms
  always_comb begin
    clip     = vv > prod[SQ_W-1:0];
    sq_start = (cmd.op == OP_CLIP) && clip;
    quo_cap  = (|div_quo[DW-1:VAL_W]) ? MAX31 : div_quo[VAL_W-1:0];
    quo_hi   = div_quo[DW-1:FRAC_BITS];
    tc_mag   = (quo_hi > (DW-FRAC_BITS)'(TC_Q_MAX)) ? MAX31 : quo_cap;
    dc_abs   = dc[63] ? 64'(-dc) : 64'(dc);
    s2       = s1 + $signed({3'b000, td});
    dv       = prod >> FRAC_BITS;
    vel_sum  = PROD_W'(cur_vel) + dv;
    pos_sum  = PROD_W'(cur_pos) + dv;
    pos_new  = (|pos_sum[PROD_W-1:VAL_W]) ? MAX31 : pos_sum[VAL_W-1:0];
    last_now = ({1'b0, elapsed} + 33'(step_period)) > {2'b00, total};
    out_free = !out_valid || out_ready;
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // profile planning terms (no reset needed, always written before use)
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT:   if (!in_func) target <= in_target;
      OP_MUL_TA:   vv <= prod[SQ_W-1:0];
      OP_TD_SET:   td <= quo_cap;
      OP_QA_SET:   dc <= $signed({33'd0, target}) - $signed({2'b00, div_quo[SQ_W-1:0]});
      OP_QD_SET:   dc <= dc - $signed({2'b00, div_quo[SQ_W-1:0]});
      OP_TC_SET:   tc <= dc[63] ? -$signed({2'b00, tc_mag}) : $signed({2'b00, tc_mag});
      OP_FIN1:     s1 <= $signed({3'b000, ta}) + $signed({tc[32], tc});
      OP_SMP_RATE: mode <= mode_now;
      default: ;
    endcase
  end

  // run state: peak, times, velocity, position, elapsed time
  always_ff @(posedge clk) begin
    if (rst) begin
      peak    <= '0;
      ta      <= '0;
      ds      <= '0;
      total   <= '0;
      cur_vel <= '0;
      cur_pos <= '0;
      elapsed <= '0;
      active  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (in_func) begin
            if (active) elapsed <= elapsed + 32'(step_period);
          end else begin
            cur_vel <= '0;
            cur_pos <= '0;
            elapsed <= '0;
            if (in_target == '0) active <= 1'b0;
          end
        end
        OP_CLIP:   if (!clip) peak <= v_nz;
        OP_SQ_SET: peak <= (sq_root == '0) ? VAL_W'(1) : sq_root;
        OP_TA_SET: ta <= quo_cap;
        OP_FIN2: begin
          ds     <= s1[33] ? '0 : ((|s1[32:31]) ? MAX31 : s1[VAL_W-1:0]);
          total  <= s2[33] ? '0 : ((|s2[32:31]) ? MAX31 : s2[VAL_W-1:0]);
          active <= 1'b1;
        end
        OP_SMP_VEL: begin
          case (mode)
            MODE_ACCEL: cur_vel <= (vel_sum > PROD_W'(peak)) ? peak : vel_sum[VAL_W-1:0];
            MODE_DECEL: cur_vel <= (dv >= PROD_W'(cur_vel)) ? '0 : cur_vel - dv[VAL_W-1:0];
            default: ;
          endcase
        end
        OP_SMP_POS: begin
          cur_pos <= pos_new;
          if (last_now) active <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register: load a sample, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_SMP_POS) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SMP_POS) begin
      out_velocity <= cur_vel;
      out_position <= pos_new;
      out_last     <= last_now;
    end
  end

  tmp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (div_quo),
    .done     (div_done)
  );

  tmp_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (prod[SQ_W-1:0]),
    .root    (sq_root),
    .done    (sq_done)
  );

  // status to the controller
  always_comb begin
    stat.func      = in_func;
    stat.tgt_zero  = (in_target == '0);
    stat.active    = active;
    stat.clip      = clip;
    stat.sqrt_done = sq_done;
    stat.div_done  = div_done;
    stat.out_free  = out_free;
  end

  a_vel_peak: assert property (@(posedge clk) disable iff (rst) active |-> cur_vel <= peak)
    else $error("velocity above peak during profile");
  a_pos_slot: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_SMP_POS) |-> out_free)
    else $error("sample loaded over a pending one");
  a_zero_abort: assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_ACCEPT && !in_func && in_target == '0) |=> !active)
    else $error("zero target did not stop the profile");

endmodule

`default_nettype wire

@@ hdl/tmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trapezoid motion profile controller
// Sequences the planning steps of a start item and the sample steps of
// every item that emits a result.
// ----------------------------------------------------------------------------
`default_nettype none

module tmp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output tmp_pkg::dp_cmd_t       cmd,
  input  wire tmp_pkg::dp_stat_t stat
);
  import tmp_pkg::*;

  typedef enum logic [21:0] {
    ST_IDLE  = 22'h000001,
    ST_MVV   = 22'h000002,
    ST_MTA   = 22'h000004,
    ST_CLIP  = 22'h000008,
    ST_SQW   = 22'h000010,
    ST_DTAG  = 22'h000020,
    ST_DTAW  = 22'h000040,
    ST_DTDG  = 22'h000080,
    ST_DTDW  = 22'h000100,
    ST_MPP   = 22'h000200,
    ST_DQAG  = 22'h000400,
    ST_DQAW  = 22'h000800,
    ST_DQDG  = 22'h001000,
    ST_DQDW  = 22'h002000,
    ST_DTCG  = 22'h004000,
    ST_DTCW  = 22'h008000,
    ST_FIN1  = 22'h010000,
    ST_FIN2  = 22'h020000,
    ST_SRATE = 22'h040000,
    ST_SVEL  = 22'h080000,
    ST_SMULP = 22'h100000,
    ST_SPOS  = 22'h200000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (stat.func) begin
            state_next = stat.active ? ST_SRATE : ST_IDLE;
          end else begin
            state_next = stat.tgt_zero ? ST_IDLE : ST_MVV;
          end
        end
      end
      ST_MVV: begin cmd.op = OP_MUL_VV; state_next = ST_MTA; end
      ST_MTA: begin cmd.op = OP_MUL_TA; state_next = ST_CLIP; end
      ST_CLIP: begin
        cmd.op     = OP_CLIP;
        state_next = stat.clip ? ST_SQW : ST_DTAG;
      end
      ST_SQW: if (stat.sqrt_done) begin cmd.op = OP_SQ_SET; state_next = ST_DTAG; end
      ST_DTAG: begin cmd.op = OP_DTA_GO; state_next = ST_DTAW; end
      ST_DTAW: if (stat.div_done) begin cmd.op = OP_TA_SET; state_next = ST_DTDG; end
      ST_DTDG: begin cmd.op = OP_DTD_GO; state_next = ST_DTDW; end
      ST_DTDW: if (stat.div_done) begin cmd.op = OP_TD_SET; state_next = ST_MPP; end
      ST_MPP:  begin cmd.op = OP_MUL_PP; state_next = ST_DQAG; end
      ST_DQAG: begin cmd.op = OP_DQA_GO; state_next = ST_DQAW; end
      ST_DQAW: if (stat.div_done) begin cmd.op = OP_QA_SET; state_next = ST_DQDG; end
      ST_DQDG: begin cmd.op = OP_DQD_GO; state_next = ST_DQDW; end
      ST_DQDW: if (stat.div_done) begin cmd.op = OP_QD_SET; state_next = ST_DTCG; end
      ST_DTCG: begin cmd.op = OP_DTC_GO; state_next = ST_DTCW; end
      ST_DTCW: if (stat.div_done) begin cmd.op = OP_TC_SET; state_next = ST_FIN1; end
      ST_FIN1:  begin cmd.op = OP_FIN1; state_next = ST_FIN2; end
      ST_FIN2:  begin cmd.op = OP_FIN2; state_next = ST_SRATE; end
      ST_SRATE: begin cmd.op = OP_SMP_RATE; state_next = ST_SVEL; end
      ST_SVEL:  begin cmd.op = OP_SMP_VEL; state_next = ST_SMULP; end
      ST_SMULP: begin cmd.op = OP_SMP_MULP; state_next = ST_SPOS; end
      // hold until the output register is free
      ST_SPOS: if (stat.out_free) begin cmd.op = OP_SMP_POS; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/trapezoid_motion_profile_unit.sv @@
// ----------------------------------------------------------------------------
// Trapezoid motion profile unit
// Plans a trapezoidal velocity profile from a start item and emits one
// velocity/position sample per accepted item while the profile runs.
//
//  channel  | direction | tdata (low bit up)           | side band
//  ---------+-----------+------------------------------+--------------------
//  s_axis   | in        | target[30:0], pad            | tuser: func
//  m_axis   | out       | velocity[30:0],              | tlast: last
//           |           | position[61:31], pad         |
//  cfg      | in        | cfg_data, index cfg_index    | write on cfg_we
//
// A tick item runs the sample steps SRATE, SVEL, SMULP and SPOS after
// acceptance, the sample being registered in SPOS; the next item can be
// taken once the unit is back in IDLE. A start item first runs the planning
// steps, with a square root only when the velocity limit clips, then the
// sample steps: five one-bit-per-cycle divisions dominate.
// Items with no result leave the unit ready in the cycle after acceptance.
// A pending sample stalls the next sample in SPOS, and acceptance waits until that sample is loaded.
// Reset (rst, synchronous) restores register defaults and stops any profile.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_motion_profile_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // target[30:0], zero [31]
  input  wire logic        s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,   // velocity[30:0], position[61:31], zero [63:62]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  import tmp_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [VAL_W-1:0] out_velocity;
  logic [VAL_W-1:0] out_position;

  tmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tmp_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_reg_t'(cfg_index)),
    .cfg_data     (cfg_data),
    .in_func      (s_axis_tuser),
    .in_target    (s_axis_tdata[VAL_W-1:0]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_velocity (out_velocity),
    .out_position (out_position),
    .out_last     (m_axis_tlast)
  );

  // pack the sample
  assign m_axis_tdata = {2'b00, out_position, out_velocity};

endmodule

`default_nettype wire
